>>> rtl/arpc_pkg.sv
// ----------------------------------------------------------------------------
// arpc_pkg
// shared types, codes and helpers of the arp responder with address cache
// ----------------------------------------------------------------------------
package arpc_pkg;

    localparam int CACHE_DEPTH_DEF = 8;
    localparam int IP_W            = 32;
    localparam int MAC_W           = 48;

    // command codes of an input request
    localparam logic [1:0] CMD_RX_HDR = 2'd0;
    localparam logic [1:0] CMD_LOOKUP = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;
    localparam logic [1:0] CMD_QUERY  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_LOCAL_IP  = 2'd0;
    localparam logic [1:0] CFG_LOCAL_MAC = 2'd1;
    localparam logic [1:0] CFG_BCAST_MAC = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_REPLY  = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;
    localparam logic [1:0] KIND_LOOKUP = 2'd3;

    // arp header field values
    localparam logic [15:0] HW_TYPE_ETH    = 16'h0001;
    localparam logic [15:0] PROTO_IPV4     = 16'h0800;
    localparam logic [7:0]  HW_LEN_ETH     = 8'd6;
    localparam logic [7:0]  PROTO_LEN_IPV4 = 8'd4;
    localparam logic [15:0] ARP_OP_REQUEST = 16'd1;
    localparam logic [15:0] ARP_OP_REPLY   = 16'd2;

    // classified operation handed from front to back
    typedef enum logic [2:0] {
        OP_NONE,
        OP_CLEAR,
        OP_QUERY,
        OP_LOOKUP,
        OP_LEARN,
        OP_LEARN_REPLY
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
    } t_req;

    typedef struct packed {
        logic [IP_W-1:0]  own_ip;
        logic [MAC_W-1:0] own_mac;
        logic [MAC_W-1:0] bcast_mac;
    } t_cfg;

    typedef struct packed {
        logic [1:0]       kind;
        logic [MAC_W-1:0] eth_dest;
        logic [15:0]      op;
        logic [MAC_W-1:0] sender_hw;
        logic [IP_W-1:0]  sender_proto;
        logic [MAC_W-1:0] target_hw;
        logic [IP_W-1:0]  target_proto;
        logic             hit;
        logic [MAC_W-1:0] lookup_hw;
    } t_result;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_RESOLVE,
        ST_OUT
    } t_state;

    function automatic int index_width(input int depth);
        index_width = (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

>>> rtl/arpc_ram.sv
// ----------------------------------------------------------------------------
// arpc_ram
// generic single-port ram with registered read data
// ----------------------------------------------------------------------------
module arpc_ram
    import arpc_pkg::*;
#(
    parameter int WIDTH = MAC_W,
    parameter int DEPTH = CACHE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic                          i_re,
    input  logic [index_width(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]              i_wdata,
    output logic [WIDTH-1:0]              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/arpc_front.sv
// ----------------------------------------------------------------------------
// arpc_front
// checks received headers and turns each command into a back-end operation
// ----------------------------------------------------------------------------
module arpc_front
    import arpc_pkg::*;
(
    input  logic [1:0]       i_cmd,
    input  logic [15:0]      i_hw_kind,
    input  logic [15:0]      i_proto_kind,
    input  logic [7:0]       i_hw_len,
    input  logic [7:0]       i_proto_len,
    input  logic [15:0]      i_op_code,
    input  logic [MAC_W-1:0] i_sender_hw,
    input  logic [IP_W-1:0]  i_sender_proto,
    input  logic [IP_W-1:0]  i_target_proto,
    input  logic [IP_W-1:0]  i_query_ip,
    input  logic [IP_W-1:0]  i_own_ip,
    output t_req             o_req
);

    logic hdr_ok;

    assign hdr_ok = (i_hw_kind == HW_TYPE_ETH) && (i_proto_kind == PROTO_IPV4) &&
                    (i_hw_len == HW_LEN_ETH) && (i_proto_len == PROTO_LEN_IPV4) &&
                    (i_target_proto == i_own_ip);

    always_comb begin
        o_req.op  = OP_NONE;
        o_req.ip  = i_query_ip;
        o_req.mac = i_sender_hw;
        unique case (i_cmd)
            CMD_RX_HDR: begin
                o_req.ip = i_sender_proto;
                if (hdr_ok && (i_op_code == ARP_OP_REPLY)) begin
                    o_req.op = OP_LEARN;
                end else if (hdr_ok && (i_op_code == ARP_OP_REQUEST)) begin
                    o_req.op = OP_LEARN_REPLY;
                end
            end
            CMD_LOOKUP: o_req.op = OP_LOOKUP;
            CMD_CLEAR:  o_req.op = OP_CLEAR;
            CMD_QUERY:  o_req.op = OP_QUERY;
            default:    o_req.op = OP_NONE;
        endcase
    end

endmodule

>>> rtl/arpc_fifo.sv
// ----------------------------------------------------------------------------
// arpc_fifo
// two-entry request queue between front and back
// ----------------------------------------------------------------------------
module arpc_fifo
    import arpc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_req i_data,
    output logic o_full,
    input  logic i_pop,
    output t_req o_data,
    output logic o_empty
);

    t_req       r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic       wr_en;
    logic       rd_en;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (wr_en) begin
                r_wptr <= ~r_wptr;
            end
            if (rd_en) begin
                r_rptr <= ~r_rptr;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 2'd1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

>>> rtl/arpc_back.sv
// ----------------------------------------------------------------------------
// arpc_back
// cache sequencer: match, update or read the cache, build the result
// ----------------------------------------------------------------------------
module arpc_back
    import arpc_pkg::*;
#(
    parameter int CACHE_DEPTH = CACHE_DEPTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_q_empty,
    input  t_req    i_q_data,
    output logic    o_q_pop,
    input  logic    i_pop,
    output logic    o_out_valid,
    output t_result o_result
);

    localparam int SLOT_W = index_width(CACHE_DEPTH);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(CACHE_DEPTH - 1);

    t_state r_state, n_state;

    t_op              r_op;
    logic [IP_W-1:0]  r_ip;
    logic [MAC_W-1:0] r_mac;
    logic [CACHE_DEPTH-1:0] r_match;
    logic             r_hit;
    logic [IP_W-1:0]  r_ip_tab [CACHE_DEPTH];
    logic [CACHE_DEPTH-1:0] r_valid;
    logic [SLOT_W-1:0] r_next;
    logic             r_out_valid, n_out_valid;
    t_result          r_out, n_out;

    logic [CACHE_DEPTH-1:0] match_vec;
    logic             hit_any;
    logic [SLOT_W-1:0] hit_slot;
    logic             out_free;
    logic             ram_we;
    logic             ram_re;
    logic [SLOT_W-1:0] ram_addr;
    logic [MAC_W-1:0] ram_rdata;
    logic             tab_wr;
    logic             tab_clr;

    arpc_ram #(
        .WIDTH (MAC_W),
        .DEPTH (CACHE_DEPTH)
    ) u_mac_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (r_mac),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        for (int i = 0; i < CACHE_DEPTH; i++) begin
            match_vec[i] = r_valid[i] && (r_ip_tab[i] == r_ip);
        end
    end

    // lowest matching slot wins
    always_comb begin
        hit_slot = '0;
        for (int i = CACHE_DEPTH - 1; i >= 0; i--) begin
            if (r_match[i]) begin
                hit_slot = SLOT_W'(i);
            end
        end
    end

    assign hit_any  = |r_match;
    assign out_free = !r_out_valid || i_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_q_pop     = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_addr    = hit_slot;
        tab_wr      = 1'b0;
        tab_clr     = 1'b0;
        n_out_valid = r_out_valid && !i_pop;
        n_out       = r_out;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    if ((i_q_data.op == OP_LOOKUP) || (i_q_data.op == OP_LEARN) ||
                        (i_q_data.op == OP_LEARN_REPLY)) begin
                        n_state = ST_MATCH;
                    end else begin
                        n_state = ST_OUT;
                    end
                end
            end
            ST_MATCH: begin
                n_state = ST_RESOLVE;
            end
            ST_RESOLVE: begin
                if (r_op == OP_LOOKUP) begin
                    ram_re = 1'b1;
                end else begin
                    // update in place on a hit, else take the round-robin slot
                    ram_we   = 1'b1;
                    ram_addr = hit_any ? hit_slot : r_next;
                    tab_wr   = !hit_any;
                end
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '0;
                    unique case (r_op)
                        OP_LEARN_REPLY: begin
                            n_out.kind         = KIND_REPLY;
                            n_out.eth_dest     = r_mac;
                            n_out.op           = ARP_OP_REPLY;
                            n_out.sender_hw    = i_cfg.own_mac;
                            n_out.sender_proto = i_cfg.own_ip;
                            n_out.target_hw    = r_mac;
                            n_out.target_proto = r_ip;
                        end
                        OP_QUERY: begin
                            n_out.kind         = KIND_QUERY;
                            n_out.eth_dest     = i_cfg.bcast_mac;
                            n_out.op           = ARP_OP_REQUEST;
                            n_out.sender_hw    = i_cfg.own_mac;
                            n_out.sender_proto = i_cfg.own_ip;
                            n_out.target_proto = r_ip;
                        end
                        OP_LOOKUP: begin
                            n_out.kind      = KIND_LOOKUP;
                            n_out.hit       = r_hit;
                            n_out.lookup_hw = r_hit ? ram_rdata : '0;
                        end
                        default: begin
                            n_out.kind = KIND_NONE;
                        end
                    endcase
                    tab_clr = (r_op == OP_CLEAR);
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_next      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (tab_clr) begin
                r_valid <= '0;
            end else if (tab_wr) begin
                r_valid[r_next] <= 1'b1;
                r_next <= (r_next == LAST_SLOT) ? '0 : r_next + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_op  <= i_q_data.op;
            r_ip  <= i_q_data.ip;
            r_mac <= i_q_data.mac;
        end
        if (r_state == ST_MATCH) begin
            r_match <= match_vec;
        end
        if (r_state == ST_RESOLVE) begin
            r_hit <= hit_any;
        end
        if (tab_wr) begin
            r_ip_tab[r_next] <= r_ip;
        end
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

`ifndef SYNTHESIS
    // an address is never held by two valid entries
    a_single_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RESOLVE) |-> $onehot0(r_match))
        else $error("cache holds the same address twice");

    a_new_entry_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tab_wr |=> r_valid[$past(r_next)])
        else $error("new cache entry not marked valid");

    a_hold_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_OUT) && r_out_valid && !i_pop) |=> (r_state == ST_OUT))
        else $error("result dropped while output register busy");
`endif

endmodule

>>> rtl/arp_responder_with_cache_unit.sv
// ----------------------------------------------------------------------------
// arp_responder_with_cache_unit
// arp responder with a small ipv4-to-mac cache
// ----------------------------------------------------------------------------
// Requests enter a two-entry queue, one per cycle while full is low; every
// request yields exactly one result, in order. A lookup, or a received reply
// or request header that passes the checks, runs through all four states of
// the back-end sequencer (dequeue, match compare against all entries, resolve
// with the mac ram access, result write); a clear, a query, a dropped header
// or a header with an unknown operation goes from dequeue to result write. The
// sustained rate is set by that sequencer, and a result waiting in the output
// register stalls it only when the next result is ready. The cache has valid
// bits cleared at reset and by a clear request, so no clearing pass is needed.
module arp_responder_with_cache_unit
    import arpc_pkg::*;
#(
    parameter int CACHE_DEPTH = CACHE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // configuration
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [MAC_W-1:0] i_cfg_data,
    // request side
    input  logic             push,
    output logic             full,
    input  logic [1:0]       i_cmd,
    input  logic [15:0]      i_hw_kind,
    input  logic [15:0]      i_proto_kind,
    input  logic [7:0]       i_hw_len,
    input  logic [7:0]       i_proto_len,
    input  logic [15:0]      i_op_code,
    input  logic [MAC_W-1:0] i_sender_hw,
    input  logic [IP_W-1:0]  i_sender_proto,
    input  logic [IP_W-1:0]  i_target_proto,
    input  logic [IP_W-1:0]  i_query_ip,
    // result side
    output logic             empty,
    input  logic             pop,
    output logic [1:0]       o_result_kind,
    output logic [MAC_W-1:0] o_eth_dest,
    output logic [15:0]      o_out_op,
    output logic [MAC_W-1:0] o_out_sender_hw,
    output logic [IP_W-1:0]  o_out_sender_proto,
    output logic [MAC_W-1:0] o_out_target_hw,
    output logic [IP_W-1:0]  o_out_target_proto,
    output logic             o_lookup_hit,
    output logic [MAC_W-1:0] o_lookup_hw
);

    t_cfg    r_cfg;
    t_req    front_req;
    t_req    q_data;
    logic    q_empty;
    logic    q_pop;
    logic    out_valid;
    t_result result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.own_ip    <= '0;
            r_cfg.own_mac   <= '0;
            r_cfg.bcast_mac <= '1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LOCAL_IP:  r_cfg.own_ip    <= i_cfg_data[IP_W-1:0];
                CFG_LOCAL_MAC: r_cfg.own_mac   <= i_cfg_data;
                CFG_BCAST_MAC: r_cfg.bcast_mac <= i_cfg_data;
                default: ;
            endcase
        end
    end

    arpc_front u_front (
        .i_cmd          (i_cmd),
        .i_hw_kind      (i_hw_kind),
        .i_proto_kind   (i_proto_kind),
        .i_hw_len       (i_hw_len),
        .i_proto_len    (i_proto_len),
        .i_op_code      (i_op_code),
        .i_sender_hw    (i_sender_hw),
        .i_sender_proto (i_sender_proto),
        .i_target_proto (i_target_proto),
        .i_query_ip     (i_query_ip),
        .i_own_ip       (r_cfg.own_ip),
        .o_req          (front_req)
    );

    arpc_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_req),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_data  (q_data),
        .o_empty (q_empty)
    );

    arpc_back #(
        .CACHE_DEPTH (CACHE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_empty   (q_empty),
        .i_q_data    (q_data),
        .o_q_pop     (q_pop),
        .i_pop       (pop),
        .o_out_valid (out_valid),
        .o_result    (result)
    );

    assign empty              = !out_valid;
    assign o_result_kind      = result.kind;
    assign o_eth_dest         = result.eth_dest;
    assign o_out_op           = result.op;
    assign o_out_sender_hw    = result.sender_hw;
    assign o_out_sender_proto = result.sender_proto;
    assign o_out_target_hw    = result.target_hw;
    assign o_out_target_proto = result.target_proto;
    assign o_lookup_hit       = result.hit;
    assign o_lookup_hw        = result.lookup_hw;

endmodule
